FILE: design/rob_pkg.sv
package rob_pkg;

  // sizing
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 10;
  localparam int DRAIN_MAX   = MAX_RESULTS - 2;
  localparam int DRAIN_W     = $clog2(DRAIN_MAX + 1);

  // field widths
  localparam int OFF_W = 32;
  localparam int CNT_W = 10;
  localparam int HDL_W = 8;

  // largest payload size taken as is
  localparam logic [15:0] MAX_BYTES = 16'd1023;

  // result codes
  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_REFUSE  = 2'd2
  } rob_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      store;
    logic      emit;
    rob_kind_t kind;
    logic      from_slot;
    logic      advance;
    logic      run_end;
  } rob_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_match;
    logic has_free;
    logic slot_hit;
    logic out_ready;
  } rob_sts_t;

endpackage

FILE: design/rob_ctrl.sv
module rob_ctrl
  import rob_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rob_sts_t sts,
  output rob_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;

  // input side is open only between packets
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    drain_nxt     = drain_r;
    cmd           = '0;
    cmd.kind      = KIND_DELIVER;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.out_ready) begin
          cmd.emit = 1'b1;
          if (sts.in_match) begin
            cmd.kind    = KIND_DELIVER;
            cmd.advance = 1'b1;
            drain_nxt   = '0;
            state_nxt   = ST_DRAIN;
          end else if (sts.has_free) begin
            cmd.store   = 1'b1;
            cmd.kind    = KIND_ACK;
            cmd.run_end = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.kind    = KIND_REFUSE;
            cmd.run_end = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (sts.out_ready) begin
          cmd.emit = 1'b1;
          if (sts.slot_hit && (drain_r < DRAIN_W'(DRAIN_MAX))) begin
            cmd.kind      = KIND_DELIVER;
            cmd.from_slot = 1'b1;
            cmd.advance   = 1'b1;
            drain_nxt     = drain_r + 1'b1;
          end else begin
            cmd.kind    = KIND_ACK;
            cmd.run_end = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

FILE: design/rob_dpath.sv
module rob_dpath
  import rob_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [OFF_W-1:0] in_seq_offset,
  input  logic [CNT_W-1:0] in_byte_count,
  input  logic             in_final_flag,
  input  logic             in_channel,
  input  logic [HDL_W-1:0] in_payload_handle,
  input  logic             out_stall,
  input  rob_cmd_t         cmd,
  output rob_sts_t         sts,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [OFF_W-1:0] out_offset,
  output logic [CNT_W-1:0] out_count,
  output logic             out_final,
  output logic             out_channel,
  output logic [HDL_W-1:0] out_handle,
  output logic             out_run_end
);

  // request held while it is worked on
  logic [OFF_W-1:0] req_off_r;
  logic [CNT_W-1:0] req_cnt_r;
  logic             req_fin_r;
  logic             req_ch_r;
  logic [HDL_W-1:0] req_hdl_r;

  logic [OFF_W-1:0] next_exp_r;

  // slot storage
  logic [SLOTS-1:0] used_r;
  logic [OFF_W-1:0] slot_off_r [SLOTS];
  logic [CNT_W-1:0] slot_cnt_r [SLOTS];
  logic             slot_fin_r [SLOTS];
  logic             slot_ch_r  [SLOTS];
  logic [HDL_W-1:0] slot_hdl_r [SLOTS];

  // output register
  logic             out_valid_r;
  rob_kind_t        out_kind_r;
  logic [OFF_W-1:0] out_off_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_fin_r;
  logic             out_ch_r;
  logic [HDL_W-1:0] out_hdl_r;
  logic             out_end_r;

  logic [CNT_W-1:0]  cnt_clamped;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic              hit_any;
  logic              free_any;
  logic [OFF_W-1:0]  sel_off;
  logic [CNT_W-1:0]  sel_cnt;
  logic              sel_fin;
  logic              sel_ch;
  logic [HDL_W-1:0]  sel_hdl;

  // oversize count saturates at the bound
  assign cnt_clamped = ({6'd0, in_byte_count} > MAX_BYTES) ?
                       MAX_BYTES[CNT_W-1:0] : in_byte_count;

  // lowest used slot at the expected offset, lowest free slot
  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && (slot_off_r[i] == next_exp_r)) begin
        hit_idx = SLOT_W'(i);
        hit_any = 1'b1;
      end
      if (!used_r[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.in_match  = (req_off_r == next_exp_r);
    sts.has_free  = free_any;
    sts.slot_hit  = hit_any;
    sts.out_ready = !out_valid_r || !out_stall;
  end

  // source of the packet being reported
  always_comb begin
    if (cmd.from_slot) begin
      sel_off = slot_off_r[hit_idx];
      sel_cnt = slot_cnt_r[hit_idx];
      sel_fin = slot_fin_r[hit_idx];
      sel_ch  = slot_ch_r[hit_idx];
      sel_hdl = slot_hdl_r[hit_idx];
    end else begin
      sel_off = req_off_r;
      sel_cnt = req_cnt_r;
      sel_fin = req_fin_r;
      sel_ch  = req_ch_r;
      sel_hdl = req_hdl_r;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_off_r <= in_seq_offset;
      req_cnt_r <= cnt_clamped;
      req_fin_r <= in_final_flag;
      req_ch_r  <= in_channel;
      req_hdl_r <= in_payload_handle;
    end
  end

  // expected offset and slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_exp_r <= '0;
      used_r     <= '0;
    end else begin
      if (cmd.advance) begin
        next_exp_r <= next_exp_r + OFF_W'(sel_cnt);
      end
      if (cmd.store) begin
        used_r[free_idx] <= 1'b1;
      end else if (cmd.from_slot) begin
        used_r[hit_idx] <= 1'b0;
      end
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      slot_off_r[free_idx] <= req_off_r;
      slot_cnt_r[free_idx] <= req_cnt_r;
      slot_fin_r[free_idx] <= req_fin_r;
      slot_ch_r[free_idx]  <= req_ch_r;
      slot_hdl_r[free_idx] <= req_hdl_r;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_off_r  <= sel_off;
      out_cnt_r  <= sel_cnt;
      out_fin_r  <= sel_fin;
      out_ch_r   <= sel_ch;
      out_hdl_r  <= (cmd.kind == KIND_DELIVER) ? sel_hdl : '0;
      out_end_r  <= cmd.run_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_offset  = out_off_r;
  assign out_count   = out_cnt_r;
  assign out_final   = out_fin_r;
  assign out_channel = out_ch_r;
  assign out_handle  = out_hdl_r;
  assign out_run_end = out_end_r;

endmodule

FILE: design/reorder_buffer_reassembly_top.sv
// Receiver reorder buffer for byte-offset sequenced packet descriptors.
// Input channel (in_valid/in_stall): one descriptor per request with offset,
// size, last flag, channel and payload handle. Result channel
// (out_valid/out_stall): one request per result; kind is deliver, acknowledge
// or refused, and out_run_end marks the last result caused by an input.
// A packet at the expected offset is delivered, then every buffered packet
// that continues the stream is delivered and its slot freed, then an
// acknowledge follows. Other packets take the lowest free slot of eight and
// are acknowledged, or are refused when all slots are full.
// Timing: the input request is captured, then the decide state registers the
// first result once the output register is free; the drain state then
// registers each further result, one result per cycle while the receiver
// does not stall, through the single output register. No new input is taken
// before the last result is registered. in_stall is high while an input is worked on.
// When the receiver stalls, the pending result holds and the drain waits.
// Reset (synchronous, rst_n low) empties all slots, sets the expected
// offset to zero and drops any pending result.
module reorder_buffer_reassembly_top
  import rob_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OFF_W-1:0] in_seq_offset,
  input  logic [CNT_W-1:0] in_byte_count,
  input  logic             in_final_flag,
  input  logic             in_channel,
  input  logic [HDL_W-1:0] in_payload_handle,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [OFF_W-1:0] out_offset,
  output logic [CNT_W-1:0] out_count,
  output logic             out_final,
  output logic             out_channel,
  output logic [HDL_W-1:0] out_handle,
  output logic             out_run_end
);

  rob_cmd_t cmd;
  rob_sts_t sts;

  // sequencing
  rob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slots, expected offset and result register
  rob_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_seq_offset     (in_seq_offset),
    .in_byte_count     (in_byte_count),
    .in_final_flag     (in_final_flag),
    .in_channel        (in_channel),
    .in_payload_handle (in_payload_handle),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_offset        (out_offset),
    .out_count         (out_count),
    .out_final         (out_final),
    .out_channel       (out_channel),
    .out_handle        (out_handle),
    .out_run_end       (out_run_end)
  );

endmodule

FILE: design/rob_checker.sv
module rob_checker
  import rob_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_kind,
  input logic [OFF_W-1:0] out_offset,
  input logic [CNT_W-1:0] out_count,
  input logic [HDL_W-1:0] out_handle,
  input logic             out_run_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_offset) &&
      $stable(out_count) && $stable(out_kind) && $stable(out_run_end))
    else $error("stalled result changed");

  // an accepted request keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // a refusal is always the only result
  a_refuse_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REFUSE) |-> out_run_end)
    else $error("refusal without run end");

  // deliveries are always followed by an acknowledge
  a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DELIVER) |-> !out_run_end)
    else $error("delivery closed a run");

  // acknowledges and refusals carry no handle
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_ACK) || (out_kind == KIND_REFUSE)) |->
      (out_handle == '0))
    else $error("handle on non-delivery");

endmodule

bind reorder_buffer_reassembly_top rob_checker u_rob_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kind    (out_kind),
  .out_offset  (out_offset),
  .out_count   (out_count),
  .out_handle  (out_handle),
  .out_run_end (out_run_end)
);
